[src/msjct_pkg.sv]
// ----------------------------------------------------------------------------
// msjct_pkg
// Shared constants, codes and types of the job completion tracker.
// ----------------------------------------------------------------------------
package msjct_pkg;

  localparam int MACHINES    = 8;
  localparam int QUEUE_DEPTH = 32;
  localparam int TIME_W      = 48;
  localparam int ID_W        = 16;
  localparam int DUR_W       = 32;
  localparam int CFG_W       = 4;
  localparam int SLOT_W      = (MACHINES > 1) ? $clog2(MACHINES) : 1;
  localparam int CNT_W       = $clog2(MACHINES + 1);
  localparam int QA_W        = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int QC_W        = $clog2(QUEUE_DEPTH + 1);
  localparam int CMP_W       = (CNT_W > CFG_W) ? CNT_W : CFG_W;

  localparam logic [TIME_W-1:0] TIME_MAX = '1;
  localparam logic [CFG_W-1:0]  CFG_RESET = CFG_W'(8);

  localparam logic OP_SUBMIT   = 1'b0;
  localparam logic OP_ADVANCE  = 1'b1;
  localparam logic KIND_DONE   = 1'b0;
  localparam logic KIND_REJECT = 1'b1;

  // running minimum handed from cell to cell
  typedef struct packed {
    logic              go;
    logic              found;
    logic [TIME_W-1:0] fin;
    logic [ID_W-1:0]   job;
    logic [SLOT_W-1:0] idx;
  } token_t;

  typedef struct packed {
    logic              wr;
    logic              clr;
    logic [TIME_W-1:0] fin;
    logic [ID_W-1:0]   job;
  } cell_cmd_t;

  typedef struct packed {
    logic [ID_W-1:0]  job;
    logic [DUR_W-1:0] dur;
  } wait_entry_t;

  typedef struct packed {
    logic              kind;
    logic [TIME_W-1:0] fin;
    logic [ID_W-1:0]   id;
  } result_t;

  typedef enum logic [2:0] {
    S_IDLE, S_QCHK, S_QRD, S_WAIT, S_RET, S_SUB, S_END
  } state_t;

endpackage

[src/msjct_if.sv]
// ----------------------------------------------------------------------------
// msjct_if
// Valid/ready channels for input items and result words.
// ----------------------------------------------------------------------------
interface msjct_job_if import msjct_pkg::*; ();
  logic              valid;
  logic              ready;
  logic              op;
  logic [TIME_W-1:0] event_time;
  logic [ID_W-1:0]   job_id;
  logic [DUR_W-1:0]  job_duration;

  modport source (output valid, op, event_time, job_id, job_duration, input ready);
  modport sink   (input valid, op, event_time, job_id, job_duration, output ready);
endinterface

interface msjct_result_if import msjct_pkg::*; ();
  logic              valid;
  logic              ready;
  logic              kind;
  logic [TIME_W-1:0] finish_time;
  logic [ID_W-1:0]   done_id;
  logic              last;

  modport source (output valid, kind, finish_time, done_id, last, input ready);
  modport sink   (input valid, kind, finish_time, done_id, last, output ready);
endinterface

[src/multi_server_job_completion_tracker.sv]
// ----------------------------------------------------------------------------
// multi_server_job_completion_tracker
// Retires jobs on a row of machine slots in finish order, feeding freed
// machines from a FIFO of waiting jobs.
// ----------------------------------------------------------------------------
// port     dir  handshake           word
// jobs     in   valid/ready         op, event_time, job_id, job_duration
// results  out  valid/ready         kind, finish_time, done_id, last
// cfg      in   cfg_wr_en           machines_in_use
//
// one item at a time; each slot scan walks the cell row
// rst is synchronous; slots and queue contents need no clearing pass
// a full result register stalls the sequencer only when a word must move
// ----------------------------------------------------------------------------
module multi_server_job_completion_tracker import msjct_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_wr_en,
  input  logic [CFG_W-1:0]     cfg_wr_data,
  msjct_job_if.sink            jobs,
  msjct_result_if.source       results
);

  state_t            state, state_next;
  logic [CFG_W-1:0]  cfg;
  logic [TIME_W-1:0] cur_time;
  logic [TIME_W-1:0] t_eff;
  logic              op_r;
  logic [ID_W-1:0]   id_r;
  logic [DUR_W-1:0]  dur_r;
  logic [CNT_W-1:0]  busy_cnt;
  logic [QA_W-1:0]   whead;
  logic [QC_W-1:0]   wcount;
  logic              pend_v;
  result_t           pend;
  logic              out_v;
  result_t           out_data;
  logic              out_last;
  token_t            res;

  token_t            tok [MACHINES+1];
  cell_cmd_t         cmd [MACHINES];
  logic [MACHINES-1:0] busy_vec;
  logic [MACHINES-1:0] free_oh;

  logic              inject, start_cell, from_q, qpush, retire;
  logic              send, send_last, pend_ld, pend_clr, set_t;
  result_t           pend_new;
  logic              ok_out, may;
  logic [CMP_W-1:0]  alw;
  logic [DUR_W-1:0]  dur_sel;
  logic [TIME_W:0]   sum;
  logic [TIME_W-1:0] fin_sat;
  logic [QA_W:0]     tail_sum;
  logic [QA_W-1:0]   tail;
  wait_entry_t       q_wr;
  wait_entry_t       q_rd;

  // clamp the machine count into 1..MACHINES
  always_comb begin
    if (cfg == '0) begin
      alw = CMP_W'(1);
    end else if (CMP_W'(cfg) > CMP_W'(MACHINES)) begin
      alw = CMP_W'(MACHINES);
    end else begin
      alw = CMP_W'(cfg);
    end
  end

  assign may     = CMP_W'(busy_cnt) < alw;
  assign ok_out  = !out_v || results.ready;
  assign dur_sel = from_q ? q_rd.dur : dur_r;
  assign sum     = {1'b0, cur_time} + (TIME_W+1)'(dur_sel);
  assign fin_sat = sum[TIME_W] ? TIME_MAX : sum[TIME_W-1:0];
  assign free_oh = ~busy_vec & (busy_vec + MACHINES'(1));

  assign tail_sum = {1'b0, whead} + (QA_W+1)'(wcount);
  assign tail = (tail_sum >= (QA_W+1)'(QUEUE_DEPTH)) ?
                QA_W'(tail_sum - (QA_W+1)'(QUEUE_DEPTH)) : tail_sum[QA_W-1:0];

  assign tok[0] = '{go: inject, found: 1'b0, fin: '0, job: '0, idx: '0};

  assign q_wr.job = id_r;
  assign q_wr.dur = dur_r;

  for (genvar i = 0; i < MACHINES; i++) begin : g_cell
    assign cmd[i].wr  = start_cell & free_oh[i];
    assign cmd[i].clr = retire && (res.idx == SLOT_W'(i));
    assign cmd[i].fin = fin_sat;
    assign cmd[i].job = from_q ? q_rd.job : id_r;

    msjct_cell u_cell (
      .clk     (clk),
      .rst     (rst),
      .idx     (SLOT_W'(i)),
      .limit   (t_eff),
      .cmd     (cmd[i]),
      .tok_in  (tok[i]),
      .tok_out (tok[i+1]),
      .busy    (busy_vec[i])
    );
  end

  msjct_wait_queue u_queue (
    .clk     (clk),
    .wr_en   (qpush),
    .wr_addr (tail),
    .wr_data (q_wr),
    .rd_addr (whead),
    .rd_data (q_rd)
  );

  assign jobs.ready          = (state == S_IDLE);
  assign results.valid       = out_v;
  assign results.kind        = out_data.kind;
  assign results.finish_time = out_data.fin;
  assign results.done_id     = out_data.id;
  assign results.last        = out_last;

  always_comb begin
    state_next = state;
    inject     = 1'b0;
    start_cell = 1'b0;
    from_q     = 1'b0;
    qpush      = 1'b0;
    retire     = 1'b0;
    send       = 1'b0;
    send_last  = 1'b0;
    pend_ld    = 1'b0;
    pend_clr   = 1'b0;
    set_t      = 1'b0;
    pend_new   = '0;
    case (state)
      S_IDLE: begin
        if (jobs.valid) state_next = S_QCHK;
      end
      S_QCHK: begin
        if (wcount != '0 && may) begin
          state_next = S_QRD;
        end else begin
          inject     = 1'b1;
          state_next = S_WAIT;
        end
      end
      S_QRD: begin
        start_cell = 1'b1;
        from_q     = 1'b1;
        state_next = S_QCHK;
      end
      S_WAIT: begin
        if (tok[MACHINES].go) state_next = S_RET;
      end
      S_RET: begin
        if (res.found) begin
          if (!pend_v || ok_out) begin
            send       = pend_v;
            pend_ld    = 1'b1;
            pend_new   = '{kind: KIND_DONE, fin: res.fin, id: res.job};
            retire     = 1'b1;
            state_next = S_QCHK;
          end
        end else begin
          set_t      = 1'b1;
          state_next = S_SUB;
        end
      end
      S_SUB: begin
        if (op_r == OP_ADVANCE) begin
          state_next = S_END;
        end else if (may) begin
          start_cell = 1'b1;
          state_next = S_END;
        end else if (wcount < QC_W'(QUEUE_DEPTH)) begin
          qpush      = 1'b1;
          state_next = S_END;
        end else if (!pend_v || ok_out) begin
          send       = pend_v;
          pend_ld    = 1'b1;
          pend_new   = '{kind: KIND_REJECT, fin: t_eff, id: id_r};
          state_next = S_END;
        end
      end
      S_END: begin
        if (!pend_v) begin
          state_next = S_IDLE;
        end else if (ok_out) begin
          send       = 1'b1;
          send_last  = 1'b1;
          pend_clr   = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg      <= CFG_RESET;
      cur_time <= '0;
      busy_cnt <= '0;
      whead    <= '0;
      wcount   <= '0;
      pend_v   <= 1'b0;
      out_v    <= 1'b0;
    end else begin
      if (cfg_wr_en) cfg <= cfg_wr_data;
      if (retire) begin
        cur_time <= res.fin;
      end else if (set_t) begin
        cur_time <= t_eff;
      end
      if (start_cell) begin
        busy_cnt <= busy_cnt + CNT_W'(1);
      end else if (retire) begin
        busy_cnt <= busy_cnt - CNT_W'(1);
      end
      if (from_q) begin
        whead  <= (whead == QA_W'(QUEUE_DEPTH - 1)) ? '0 : whead + QA_W'(1);
        wcount <= wcount - QC_W'(1);
      end else if (qpush) begin
        wcount <= wcount + QC_W'(1);
      end
      if (pend_ld) begin
        pend_v <= 1'b1;
      end else if (pend_clr) begin
        pend_v <= 1'b0;
      end
      if (send) begin
        out_v <= 1'b1;
      end else if (results.ready) begin
        out_v <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (jobs.valid && jobs.ready) begin
      t_eff <= (jobs.event_time < cur_time) ? cur_time : jobs.event_time;
      op_r  <= jobs.op;
      id_r  <= jobs.job_id;
      dur_r <= jobs.job_duration;
    end
    if (state == S_WAIT) res <= tok[MACHINES];
    if (pend_ld) pend <= pend_new;
    if (send) begin
      out_data <= pend;
      out_last <= send_last;
    end
  end

`ifndef SYNTHESIS
  a_busy_cnt: assert property (@(posedge clk) disable iff (rst)
    busy_cnt == CNT_W'($countones(busy_vec)))
    else $error("busy count out of step with slots");
  a_wcount: assert property (@(posedge clk) disable iff (rst)
    wcount <= QC_W'(QUEUE_DEPTH))
    else $error("wait count over depth");
  a_scan_limit: assert property (@(posedge clk) disable iff (rst)
    state == S_WAIT && tok[MACHINES].go && tok[MACHINES].found |->
    tok[MACHINES].fin <= t_eff)
    else $error("scan picked a job past the item time");
  a_send: assert property (@(posedge clk) disable iff (rst)
    send |=> results.valid)
    else $error("result word lost");
`endif

endmodule

[src/msjct_cell.sv]
// ----------------------------------------------------------------------------
// msjct_cell
// One machine slot: holds its job and folds itself into the passing minimum.
// ----------------------------------------------------------------------------
module msjct_cell import msjct_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic [SLOT_W-1:0] idx,
  input  logic [TIME_W-1:0] limit,
  input  cell_cmd_t         cmd,
  input  token_t            tok_in,
  output token_t            tok_out,
  output logic              busy
);

  logic [TIME_W-1:0] fin;
  logic [ID_W-1:0]   job;
  logic              take;

  // strict compare keeps the earlier slot on ties
  assign take = busy && (fin <= limit) && (!tok_in.found || fin < tok_in.fin);

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
    end else if (cmd.wr) begin
      busy <= 1'b1;
    end else if (cmd.clr) begin
      busy <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.wr) begin
      fin <= cmd.fin;
      job <= cmd.job;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      tok_out.go <= 1'b0;
    end else begin
      tok_out.go <= tok_in.go;
    end
    if (take) begin
      tok_out.found <= 1'b1;
      tok_out.fin   <= fin;
      tok_out.job   <= job;
      tok_out.idx   <= idx;
    end else begin
      tok_out.found <= tok_in.found;
      tok_out.fin   <= tok_in.fin;
      tok_out.job   <= tok_in.job;
      tok_out.idx   <= tok_in.idx;
    end
  end

endmodule

[src/msjct_wait_queue.sv]
// ----------------------------------------------------------------------------
// msjct_wait_queue
// Storage of waiting jobs, one write and one registered read per cycle.
// ----------------------------------------------------------------------------
module msjct_wait_queue import msjct_pkg::*; (
  input  logic              clk,
  input  logic              wr_en,
  input  logic [QA_W-1:0]   wr_addr,
  input  wait_entry_t       wr_data,
  input  logic [QA_W-1:0]   rd_addr,
  output wait_entry_t       rd_data
);

  wait_entry_t mem [QUEUE_DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

[test/tb_top.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Drives job and advance items into the completion tracker under random
// stalls, predicts retirements and rejections, and checks every result word.
// ----------------------------------------------------------------------------
module tb_top;
  import msjct_pkg::*;

  typedef struct packed {
    logic              op;
    logic [TIME_W-1:0] t;
    logic [ID_W-1:0]   id;
    logic [DUR_W-1:0]  dur;
  } job_item_t;

  typedef struct packed {
    logic              kind;
    logic [TIME_W-1:0] fin;
    logic [ID_W-1:0]   id;
    logic              last;
  } done_word_t;

  logic clk;
  logic rst;
  logic cfg_wr_en;
  logic [CFG_W-1:0] cfg_wr_data;

  msjct_job_if    jobs ();
  msjct_result_if results ();

  multi_server_job_completion_tracker dut (
    .clk         (clk),
    .rst         (rst),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .jobs        (jobs),
    .results     (results)
  );

  // tracker shadow state
  logic [CFG_W-1:0]  m_cfg;
  logic [TIME_W-1:0] now_t;
  logic              busy [MACHINES];
  logic [TIME_W-1:0] fin_at [MACHINES];
  logic [ID_W-1:0]   job_at [MACHINES];
  logic [ID_W-1:0]   wq_id [$];
  logic [DUR_W-1:0]  wq_dur [$];

  job_item_t  pending_items [$];
  done_word_t expected_words [$];
  int  errors = 0;
  int  sent = 0;
  bit  drive_calm = 0;
  bit  sink_calm = 0;

  initial begin
    clk = 0;
    forever #2 clk = ~clk;
  end

  initial begin
    #20000000;
    $display("tb: failure");
    $finish;
  end

  function automatic bit can_start();
    int n;
    int lim;
    n = 0;
    for (int i = 0; i < MACHINES; i++) if (busy[i]) n++;
    lim = (m_cfg == 0) ? 1 : (m_cfg > MACHINES ? MACHINES : int'(m_cfg));
    return n < lim;
  endfunction

  function automatic void start_on_slot(logic [TIME_W-1:0] at, logic [ID_W-1:0] id,
                                        logic [DUR_W-1:0] dur);
    logic [TIME_W:0] f;
    f = {1'b0, at} + (TIME_W+1)'(dur);
    for (int i = 0; i < MACHINES; i++) begin
      if (!busy[i]) begin
        busy[i] = 1;
        fin_at[i] = f[TIME_W] ? TIME_MAX : f[TIME_W-1:0];
        job_at[i] = id;
        return;
      end
    end
  endfunction

  function automatic void pop_waiting(logic [TIME_W-1:0] at);
    start_on_slot(at, wq_id.pop_front(), wq_dur.pop_front());
  endfunction

  function automatic void queue_word(done_word_t w);
    expected_words.insert(expected_words.size(), w);
  endfunction

  function automatic void predict_completions(job_item_t it);
    logic [TIME_W-1:0] t;
    done_word_t w;
    int best;
    int n0;
    n0 = expected_words.size();
    t = (it.t < now_t) ? now_t : it.t;
    while (wq_id.size() > 0 && can_start()) pop_waiting(now_t);
    forever begin
      best = -1;
      for (int i = 0; i < MACHINES; i++)
        if (busy[i] && fin_at[i] <= t && (best < 0 || fin_at[i] < fin_at[best])) best = i;
      if (best < 0) break;
      now_t = fin_at[best];
      w = '{KIND_DONE, now_t, job_at[best], 1'b0};
      queue_word(w);
      busy[best] = 0;
      if (wq_id.size() > 0 && can_start()) pop_waiting(now_t);
    end
    now_t = t;
    if (it.op == OP_SUBMIT) begin
      if (can_start()) start_on_slot(t, it.id, it.dur);
      else if (wq_id.size() < QUEUE_DEPTH) begin
        wq_id.insert(wq_id.size(), it.id);
        wq_dur.insert(wq_dur.size(), it.dur);
      end else begin
        w = '{KIND_REJECT, t, it.id, 1'b0};
        queue_word(w);
      end
    end
    if (expected_words.size() > n0) expected_words[$].last = 1'b1;
  endfunction

  // item driver
  always @(posedge clk) begin
    if (rst) begin
      jobs.valid <= 0;
    end else begin
      if (jobs.valid && jobs.ready) begin
        predict_completions({jobs.op, jobs.event_time, jobs.job_id, jobs.job_duration});
        sent++;
      end
      if ((!jobs.valid || jobs.ready) ) begin
        if (pending_items.size() > 0 && (drive_calm || $urandom_range(99) >= 26)) begin
          job_item_t it;
          it = pending_items.pop_front();
          jobs.valid <= 1;
          jobs.op <= it.op;
          jobs.event_time <= it.t;
          jobs.job_id <= it.id;
          jobs.job_duration <= it.dur;
        end else begin
          jobs.valid <= 0;
        end
      end
    end
  end

  // result monitor
  always @(posedge clk) begin
    if (rst) begin
      results.ready <= 0;
    end else begin
      if (results.valid && results.ready) begin
        if (expected_words.size() == 0) begin
          $error("unexpected word kind=%0d id=%0d", results.kind, results.done_id);
          errors++;
        end else begin
          done_word_t w;
          w = expected_words.pop_front();
          if (results.kind !== w.kind) begin
            $error("kind exp %0d got %0d", w.kind, results.kind); errors++;
          end
          if (results.finish_time !== w.fin) begin
            $error("finish_time exp %0d got %0d", w.fin, results.finish_time); errors++;
          end
          if (results.done_id !== w.id) begin
            $error("done_id exp %0d got %0d", w.id, results.done_id); errors++;
          end
          if (results.last !== w.last) begin
            $error("last exp %0d got %0d", w.last, results.last); errors++;
          end
        end
      end
      results.ready <= sink_calm || ($urandom_range(99) >= 26);
    end
  end

  task automatic add_item(logic op, logic [TIME_W-1:0] t, logic [ID_W-1:0] id,
                          logic [DUR_W-1:0] dur);
    pending_items.insert(pending_items.size(), '{op, t, id, dur});
  endtask

  task automatic drain();
    int target;
    target = sent + pending_items.size();
    while (sent < target || jobs.valid || pending_items.size() > 0) @(posedge clk);
    while (expected_words.size() > 0) @(posedge clk);
    repeat (400) @(posedge clk);
  endtask

  task automatic write_machines(logic [CFG_W-1:0] v);
    @(posedge clk);
    cfg_wr_en <= 1;
    cfg_wr_data <= v;
    m_cfg = v;
    @(posedge clk);
    cfg_wr_en <= 0;
  endtask

  task automatic random_phase(int count, logic [TIME_W-1:0] base);
    logic [TIME_W-1:0] t;
    logic [DUR_W-1:0] d;
    t = base;
    for (int k = 0; k < count; k++) begin
      t = t + $urandom_range(40);
      case ($urandom_range(9))
        0: d = $urandom();
        1: d = 0;
        default: d = $urandom_range(120);
      endcase
      if ($urandom_range(9) == 0)
        add_item(OP_ADVANCE, t + $urandom_range(300), ID_W'($urandom()), $urandom());
      else if ($urandom_range(19) == 0)
        add_item(OP_SUBMIT, t - $urandom_range(50), ID_W'($urandom()), d);
      else add_item(OP_SUBMIT, t, ID_W'($urandom()), d);
    end
    add_item(OP_ADVANCE, TIME_MAX, 0, 0);
  endtask

  initial begin
    logic [TIME_W-1:0] t0;
    rst = 1;
    cfg_wr_en = 0;
    cfg_wr_data = '0;
    jobs.valid = 0;
    jobs.op = 0;
    jobs.event_time = '0;
    jobs.job_id = '0;
    jobs.job_duration = '0;
    results.ready = 0;
    m_cfg = CFG_RESET;
    now_t = '0;
    for (int i = 0; i < MACHINES; i++) begin
      busy[i] = 0; fin_at[i] = '0; job_at[i] = '0;
    end
    repeat (11) @(posedge clk);
    rst <= 0;

    // directed: zero duration, ties, saturation, backwards time, queue full
    add_item(OP_SUBMIT, 10, 16'h0000, 0);
    add_item(OP_SUBMIT, 10, 16'hFFFF, 5);
    add_item(OP_SUBMIT, 10, 16'h0002, 5);
    add_item(OP_SUBMIT, 3, 16'h0003, 32'hFFFF_FFFF);
    add_item(OP_ADVANCE, 20, 16'h1234, 7);
    add_item(OP_SUBMIT, TIME_MAX - 2, 16'h5555, 32'hFFFF_FFFF);
    add_item(OP_ADVANCE, TIME_MAX, 16'hAAAA, 0);
    drain();

    write_machines(1);
    for (int k = 0; k < 35; k++) add_item(OP_SUBMIT, 5, 16'(k + 100), k[0] ? 0 : 3);
    add_item(OP_ADVANCE, 1000, 0, 0);
    drain();
    // raised count lets waiting jobs start at current time
    for (int k = 0; k < 5; k++) add_item(OP_SUBMIT, 2000, 16'(k + 300), 50);
    drain();
    write_machines(8);
    add_item(OP_ADVANCE, TIME_MAX, 0, 0);
    drain();

    write_machines(0);
    random_phase(30, 0);
    drain();
    write_machines(4'hF);
    drive_calm = 1; sink_calm = 1;
    random_phase(30, 0);
    drain();
    drive_calm = 0; sink_calm = 0;
    write_machines(3);
    t0 = 48'h8000_0000_0000 | 48'($urandom());
    random_phase(30, t0);
    drain();
    write_machines(2);
    random_phase(25, 0);
    drain();

    if (errors == 0 && expected_words.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end
endmodule
